// ===== hw/rtl/dual_tone_beat_generator_assert.svh =====
// Assertion macros shared by the beat generator files.
`ifndef DUAL_TONE_BEAT_GENERATOR_ASSERT_SVH
`define DUAL_TONE_BEAT_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define DTBG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtbg assertion failed");

// Next-cycle implication.
`define DTBG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtbg assertion failed");

`endif

// ===== hw/rtl/dtbg_pkg.sv =====
package dtbg_pkg;

   localparam int SINE_ADDR_BITS = 10;
   localparam int PHASE_BITS     = 40;
   localparam int TIME_BITS      = 48;

   localparam int ROM_DEPTH = 1 << SINE_ADDR_BITS;
   localparam int HALF_BITS = (PHASE_BITS + 1) / 2;
   localparam int HIGH_BITS = PHASE_BITS - HALF_BITS;

   localparam int TIME_W   = 48;
   localparam int STEP_W   = 40;
   localparam int GAIN_W   = 24;
   localparam int LEVEL_W  = 32;
   localparam int SAMPLE_W = 32;
   localparam int SINE_W   = 16;
   localparam int SUM_W    = SINE_W + 1;
   localparam int PROD_W   = SUM_W + GAIN_W;
   localparam int FRAC_DROP = 15;
   localparam int ACC_W    = LEVEL_W + FRAC_DROP + 1;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   localparam logic [1:0] CSR_FIRST_STEP  = 2'd0;
   localparam logic [1:0] CSR_SECOND_STEP = 2'd1;
   localparam logic [1:0] CSR_GAIN        = 2'd2;
   localparam logic [1:0] CSR_LEVEL       = 2'd3;

   localparam logic [STEP_W-1:0]         FIRST_STEP_RESET  = STEP_W'(1099512);
   localparam logic [STEP_W-1:0]         SECOND_STEP_RESET = STEP_W'(1209463);
   localparam logic signed [GAIN_W-1:0]  GAIN_RESET        = GAIN_W'(65536);
   localparam logic signed [LEVEL_W-1:0] LEVEL_RESET       = '0;

   typedef struct packed {
      logic [STEP_W-1:0]         first_step;
      logic [STEP_W-1:0]         second_step;
      logic signed [GAIN_W-1:0]  gain;
      logic signed [LEVEL_W-1:0] level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                quad;
      logic [SINE_ADDR_BITS-1:0] idx;
   } tone_addr_type;

endpackage

// ===== hw/rtl/dtbg_channels.sv =====
interface dtbg_req_if import dtbg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] time_us;

   modport source (output valid, output time_us, input ready);
   modport sink (input valid, input time_us, output ready);
endinterface

interface dtbg_rsp_if import dtbg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

// ===== hw/rtl/dtbg_csr.sv =====
module dtbg_csr import dtbg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [STEP_W-1:0]         first_step_ff, first_step_in;
   logic [STEP_W-1:0]         second_step_ff, second_step_in;
   logic signed [GAIN_W-1:0]  gain_ff, gain_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic                      wr_en;
   logic [1:0]                index;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = paddr[CSR_ADDR_W-1:3];

   always_comb begin
      first_step_in  = first_step_ff;
      second_step_in = second_step_ff;
      gain_in        = gain_ff;
      level_in       = level_ff;
      if (wr_en) begin
         case (index)
            CSR_FIRST_STEP:  first_step_in  = pwdata[STEP_W-1:0];
            CSR_SECOND_STEP: second_step_in = pwdata[STEP_W-1:0];
            CSR_GAIN:        gain_in        = $signed(pwdata[GAIN_W-1:0]);
            CSR_LEVEL:       level_in       = $signed(pwdata[LEVEL_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_step_ff  <= FIRST_STEP_RESET;
         second_step_ff <= SECOND_STEP_RESET;
         gain_ff        <= GAIN_RESET;
         level_ff       <= LEVEL_RESET;
      end else begin
         first_step_ff  <= first_step_in;
         second_step_ff <= second_step_in;
         gain_ff        <= gain_in;
         level_ff       <= level_in;
      end
   end

   always_comb begin
      case (index)
         CSR_FIRST_STEP:  prdata = CSR_DATA_W'(first_step_ff);
         CSR_SECOND_STEP: prdata = CSR_DATA_W'(second_step_ff);
         CSR_GAIN:        prdata = CSR_DATA_W'(gain_ff);
         CSR_LEVEL:       prdata = CSR_DATA_W'(level_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg.first_step  = first_step_ff;
   assign cfg.second_step = second_step_ff;
   assign cfg.gain        = gain_ff;
   assign cfg.level       = level_ff;

endmodule

// ===== hw/rtl/dtbg_phase.sv =====
module dtbg_phase import dtbg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [TIME_W-1:0]   time_us,
   input  cfg_type             cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output tone_addr_type [1:0] out_addr
);

   `include "dual_tone_beat_generator_assert.svh"

   localparam logic [TIME_W-1:0] TIME_MASK =
      (TIME_BITS >= TIME_W) ? '1 : TIME_W'((64'd1 << TIME_BITS) - 64'd1);

   logic [63:0]                t_wide;
   logic [PHASE_BITS-1:0]      t_phase;
   logic [HALF_BITS-1:0]       t_low;
   logic [HIGH_BITS-1:0]       t_high;
   logic [1:0][63:0]           step_wide;
   logic [1:0][HALF_BITS-1:0]  s_low;
   logic [1:0][HIGH_BITS-1:0]  s_high;
   logic [1:0][2*HALF_BITS-1:0]         ll_full;
   logic [1:0][HALF_BITS+HIGH_BITS-1:0] lh_full;
   logic [1:0][HALF_BITS+HIGH_BITS-1:0] hl_full;

   logic                        s1_valid_ff;
   logic                        s1_ready;
   logic [1:0][PHASE_BITS-1:0]  ll_ff;
   logic [1:0][HIGH_BITS-1:0]   lh_ff;
   logic [1:0][HIGH_BITS-1:0]   hl_ff;

   logic                        s2_valid_ff;
   logic                        s2_ready;
   logic [1:0][PHASE_BITS-1:0]  phase;
   tone_addr_type [1:0]         addr_in;
   tone_addr_type [1:0]         addr_ff;

   assign t_wide  = 64'(time_us & TIME_MASK);
   assign t_phase = t_wide[PHASE_BITS-1:0];
   assign t_low   = t_phase[HALF_BITS-1:0];
   assign t_high  = t_phase[PHASE_BITS-1:HALF_BITS];

   assign step_wide[0] = 64'(cfg.first_step);
   assign step_wide[1] = 64'(cfg.second_step);

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         s_low[t]   = step_wide[t][HALF_BITS-1:0];
         s_high[t]  = step_wide[t][PHASE_BITS-1:HALF_BITS];
         ll_full[t] = (2*HALF_BITS)'(t_low) * (2*HALF_BITS)'(s_low[t]);
         lh_full[t] = (HALF_BITS+HIGH_BITS)'(t_low) * (HALF_BITS+HIGH_BITS)'(s_high[t]);
         hl_full[t] = (HALF_BITS+HIGH_BITS)'(t_high) * (HALF_BITS+HIGH_BITS)'(s_low[t]);
      end
   end

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         for (int t = 0; t < 2; t++) begin
            ll_ff[t] <= ll_full[t][PHASE_BITS-1:0];
            lh_ff[t] <= lh_full[t][HIGH_BITS-1:0];
            hl_ff[t] <= hl_full[t][HIGH_BITS-1:0];
         end
      end
   end

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         phase[t] = ll_ff[t] + {lh_ff[t] + hl_ff[t], {HALF_BITS{1'b0}}};
         addr_in[t].quad = phase[t][PHASE_BITS-1 -: 2];
         addr_in[t].idx  = phase[t][PHASE_BITS-3 -: SINE_ADDR_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         addr_ff <= addr_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_addr  = addr_ff;

   `DTBG_ASSERT_NEXT(a_take_fills_s1, clock, reset, in_valid && in_ready, s1_valid_ff)

endmodule

// ===== hw/rtl/dtbg_sine_rom.sv =====
module dtbg_sine_rom import dtbg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tone_addr_type [1:0]    in_addr,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [1:0][SINE_W-1:0] out_mag,
   output logic [1:0]             out_neg
);

   typedef logic [SINE_W-1:0] sine_rom_type [ROM_DEPTH];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SINE_MAX    = 64'd32767;
   localparam logic [63:0] TAYLOR_DIV [12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] s;
      logic [SINE_W-1:0]  e;
      int                 k;
      x    = (HALF_PI_Q30 * (64'(i) * 64'd2 + 64'd1)) >> (SINE_ADDR_BITS + 1);
      x2   = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      for (k = 0; k < 12; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (k % 2 == 0) begin
            s = s - $signed(term);
         end else begin
            s = s + $signed(term);
         end
      end
      if (s < 0) begin
         e = '0;
      end else begin
         v = ($unsigned(s) * SINE_MAX + (64'd1 << 29)) >> 30;
         e = (v > SINE_MAX) ? SINE_W'(SINE_MAX) : v[SINE_W-1:0];
      end
      return e;
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type r;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         r[i] = sine_entry(i);
      end
      return r;
   endfunction

   localparam sine_rom_type ROM_TABLE = build_sine_rom();

   logic                          valid_ff;
   logic                          ready;
   logic [1:0][SINE_ADDR_BITS-1:0] rd_addr;
   logic [1:0][SINE_W-1:0]        mag_ff;
   logic [1:0]                    neg_ff;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         rd_addr[t] = in_addr[t].quad[0] ? ~in_addr[t].idx : in_addr[t].idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         for (int t = 0; t < 2; t++) begin
            mag_ff[t] <= ROM_TABLE[rd_addr[t]];
            neg_ff[t] <= in_addr[t].quad[1];
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule

// ===== hw/rtl/dtbg_mix.sv =====
module dtbg_mix import dtbg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [1:0][SINE_W-1:0]     in_mag,
   input  logic [1:0]                 in_neg,
   input  cfg_type                    cfg,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [SAMPLE_W-1:0] sample_value
);

   `include "dual_tone_beat_generator_assert.svh"

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_DROP - 1);
   localparam int R_W = ACC_W - FRAC_DROP;
   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic signed [1:0][SUM_W-1:0] tone;
   logic signed [SUM_W-1:0]      sum;
   logic signed [PROD_W-1:0]     p_in;
   logic signed [PROD_W-1:0]     p_ff;
   logic                         p_valid_ff;
   logic                         p_ready;

   logic signed [ACC_W-1:0]      acc;
   logic signed [R_W-1:0]        r;
   logic signed [SAMPLE_W-1:0]   sample_in;
   logic signed [SAMPLE_W-1:0]   sample_ff;
   logic                         out_valid_ff;
   logic                         out_stage_ready;

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         tone[t] = in_neg[t] ? -$signed({1'b0, in_mag[t]}) : $signed({1'b0, in_mag[t]});
      end
      sum  = $signed(tone[0]) + $signed(tone[1]);
      p_in = PROD_W'(sum) * PROD_W'(cfg.gain);
   end

   assign out_stage_ready = !out_valid_ff || out_ready;
   assign p_ready         = !p_valid_ff || out_stage_ready;
   assign in_ready        = p_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_ready) begin
         p_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready) begin
         p_ff <= p_in;
      end
   end

   always_comb begin
      acc = ACC_W'(p_ff) + ROUND_HALF + (ACC_W'(cfg.level) <<< FRAC_DROP);
      r   = acc[ACC_W-1:FRAC_DROP];
      if (r[R_W-1] != r[SAMPLE_W-1]) begin
         sample_in = r[R_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         sample_in = r[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_stage_ready) begin
         out_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_stage_ready) begin
         sample_ff <= sample_in;
      end
   end

   assign out_valid    = out_valid_ff;
   assign sample_value = sample_ff;

   `DTBG_ASSERT_NEXT(a_prod_hold, clock, reset, p_valid_ff && !p_ready, p_valid_ff && $stable(p_ff))

endmodule

// ===== hw/rtl/dual_tone_beat_generator.sv =====
// channel   direction  handshake      payload
// req       in         valid/ready    time_us       48b unsigned, microseconds
// rsp       out        valid/ready    sample_value  32b signed Q16.16, saturated
// csr       in         APB, pready=1  64b data, register i at byte 8*i
//
// One word in and one word out per cycle while rsp is ready; there is one stage each for
// the partial phase products, the phase sum, the two-port sine ROM read, the gain
// multiply and the offset add with rounding and saturation.
// Reset clears every stage valid bit and loads the register reset values.
// Ready runs back through all stages in the same cycle: a stall at rsp holds req at once
// when every stage is full; empty stages keep filling meanwhile.
module dual_tone_beat_generator import dtbg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dtbg_req_if.sink              req,
   dtbg_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   `include "dual_tone_beat_generator_assert.svh"

   cfg_type                cfg;
   logic                   addr_valid;
   logic                   addr_ready;
   tone_addr_type [1:0]    addr;
   logic                   mag_valid;
   logic                   mag_ready;
   logic [1:0][SINE_W-1:0] mag;
   logic [1:0]             neg;

   dtbg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dtbg_phase u_phase (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .time_us   (req.time_us),
      .cfg       (cfg),
      .out_valid (addr_valid),
      .out_ready (addr_ready),
      .out_addr  (addr)
   );

   dtbg_sine_rom u_rom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (addr_valid),
      .in_ready  (addr_ready),
      .in_addr   (addr),
      .out_valid (mag_valid),
      .out_ready (mag_ready),
      .out_mag   (mag),
      .out_neg   (neg)
   );

   dtbg_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mag_valid),
      .in_ready     (mag_ready),
      .in_mag       (mag),
      .in_neg       (neg),
      .cfg          (cfg),
      .out_valid    (rsp.valid),
      .out_ready    (rsp.ready),
      .sample_value (rsp.sample_value)
   );

   `DTBG_ASSERT_SAME(a_stall_from_rsp, clock, reset, !req.ready, rsp.valid && !rsp.ready)

endmodule
